@@ src/assert_macros.svh @@
// Concurrent assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, masked during reset
`define SMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// Implication in the following cycle, also checked through reset
`define SMS_ASSERT_NXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

@@ src/sms_pkg.sv @@
package sms_pkg;

   localparam int GUARD_BITS = 31;
   localparam int MAX_ORDER  = 6;
   localparam int DEG_MAX    = 2 * MAX_ORDER + 1;
   localparam int BERN_TERMS = MAX_ORDER + 1;
   localparam int DG_W       = 45;
   localparam int SUM_W      = 34;
   localparam int STEP_W     = 17;
   localparam int SLOPE_W    = 31;

   typedef logic [31:0]        guard_type;
   typedef logic [2:0]         order_type;
   typedef logic [1:0]         reg_index_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [SLOPE_W-1:0] slope_type;

   localparam reg_index_type REG_LOWER_EDGE = 2'd0;
   localparam reg_index_type REG_UPPER_EDGE = 2'd1;
   localparam reg_index_type REG_POLY_ORDER = 2'd2;

   localparam guard_type GONE       = guard_type'(64'd1 << GUARD_BITS);
   localparam step_type  STEP_MAX   = '1;
   localparam slope_type SLOPE_MAX  = '1;
   localparam order_type ORDER_TOP  = order_type'(MAX_ORDER);

   // Bernstein weights C(2N+1, N+1+k), row N, column k (row 0 is all zero)
   localparam logic [10:0] BERN_COEF [0:MAX_ORDER][0:MAX_ORDER] = '{
      '{11'd0,    11'd0,    11'd0,   11'd0,   11'd0,  11'd0,  11'd0},
      '{11'd3,    11'd1,    11'd0,   11'd0,   11'd0,  11'd0,  11'd0},
      '{11'd10,   11'd5,    11'd1,   11'd0,   11'd0,  11'd0,  11'd0},
      '{11'd35,   11'd21,   11'd7,   11'd1,   11'd0,  11'd0,  11'd0},
      '{11'd126,  11'd84,   11'd36,  11'd9,   11'd1,  11'd0,  11'd0},
      '{11'd462,  11'd330,  11'd165, 11'd55,  11'd11, 11'd1,  11'd0},
      '{11'd1716, 11'd1287, 11'd715, 11'd286, 11'd78, 11'd13, 11'd1}
   };

   localparam logic [13:0] DERIV_GAIN [0:MAX_ORDER] = '{
      14'd1, 14'd6, 14'd30, 14'd140, 14'd630, 14'd2772, 14'd12012
   };

   // Product of two guard-precision values, rounded half up
   function automatic guard_type gmul(input guard_type a, input guard_type b);
      logic [63:0] p;
      p = 64'(a) * 64'(b) + (64'd1 << (GUARD_BITS - 1));
      return p[GUARD_BITS+31:GUARD_BITS];
   endfunction

endpackage

@@ src/smoothstep_with_slope.sv @@
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Depth is set by the bit-serial normaliser (FRAC_BITS + 1 stages), the thirteen power
// stages, four combine stages and the 32-stage slope divider.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults:
// lower_edge 0, upper_edge 0x0001_0000 (1.0 when FRAC_BITS = 16), poly_order 1.
`include "assert_macros.svh"

module smoothstep_with_slope #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // step_value, slope
   output logic        rsp_tuser,   // range_error
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int F      = FRAC_BITS;
   localparam int G      = sms_pkg::GUARD_BITS;
   localparam int GS     = G - F;
   localparam int NUM_SH = (2 * F >= G) ? 2 * F - G : 0;
   localparam int DEN_SH = (2 * F >= G) ? 0 : G - 2 * F;
   localparam int NUM_W  = sms_pkg::DG_W + NUM_SH;
   localparam int DEN_W  = 32 + DEN_SH;
   localparam int CW     = DEN_W + G;
   localparam int PW     = 2 * sms_pkg::MAX_ORDER;
   localparam int DM     = sms_pkg::DEG_MAX;
   localparam int BT     = sms_pkg::BERN_TERMS;
   localparam int SUM_W  = sms_pkg::SUM_W;
   localparam int SW     = SUM_W + 1;
   localparam int QS     = sms_pkg::SLOPE_W;

   logic [31:0]          lower_ff, upper_ff;
   sms_pkg::order_type   order_ff, ord;
   logic                 adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= 32'h0001_0000;
         order_ff <= 3'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            sms_pkg::REG_LOWER_EDGE: lower_ff <= csr_wdata;
            sms_pkg::REG_UPPER_EDGE: upper_ff <= csr_wdata;
            sms_pkg::REG_POLY_ORDER: order_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign ord = (order_ff > sms_pkg::ORDER_TOP) ? sms_pkg::ORDER_TOP : order_ff;

   // ---------------- normalise: t = offs * 2^F / span ----------------
   logic              dv_v_ff    [0:F];
   logic              dv_e_ff    [0:F];
   logic              dv_z_ff    [0:F];
   logic              dv_o_ff    [0:F];
   logic [31:0]       dv_span_ff [0:F];
   logic [31:0]       dv_rem_ff  [0:F];
   logic [F-1:0]      dv_q_ff    [0:F];

   logic signed [32:0] lo_in, hi_in, x_in, span_in, offs_in;

   always_comb begin
      lo_in   = {lower_ff[31], lower_ff};
      hi_in   = {upper_ff[31], upper_ff};
      x_in    = {req_tdata[31], req_tdata};
      span_in = hi_in - lo_in;
      offs_in = x_in - lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= req_tvalid;
      end
      if (adv) begin
         dv_e_ff[0]    <= hi_in <= lo_in;
         dv_z_ff[0]    <= offs_in <= 33'sd0;
         dv_o_ff[0]    <= offs_in >= span_in;
         dv_span_ff[0] <= span_in[31:0];
         dv_rem_ff[0]  <= offs_in[31:0];
         dv_q_ff[0]    <= '0;
      end
   end

   for (genvar i = 1; i <= F; i++) begin : g_norm
      logic [32:0] sh;
      logic        ge;
      logic [31:0] rem_in;
      always_comb begin
         sh     = {dv_rem_ff[i-1], 1'b0};
         ge     = sh >= {1'b0, dv_span_ff[i-1]};
         rem_in = ge ? 32'(sh - {1'b0, dv_span_ff[i-1]}) : sh[31:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[i] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[i] <= dv_v_ff[i-1];
         end
         if (adv) begin
            dv_e_ff[i]    <= dv_e_ff[i-1];
            dv_z_ff[i]    <= dv_z_ff[i-1];
            dv_o_ff[i]    <= dv_o_ff[i-1];
            dv_span_ff[i] <= dv_span_ff[i-1];
            dv_rem_ff[i]  <= rem_in;
            dv_q_ff[i]    <= {dv_q_ff[i-1][F-2:0], ge};
         end
      end
   end

   // ---------------- powers of tg and ug ----------------
   logic                  pw_v_ff    [0:PW];
   logic                  pw_e_ff    [0:PW];
   logic [F:0]            pw_t_ff    [0:PW];
   logic [31:0]           pw_span_ff [0:PW];
   sms_pkg::guard_type    pw_tp_ff   [0:PW][1:DM];
   sms_pkg::guard_type    pw_up_ff   [0:PW][1:DM];

   logic [F:0]            t_in;
   sms_pkg::guard_type    tg_in;

   always_comb begin
      if (dv_o_ff[F]) begin
         t_in = {1'b1, {F{1'b0}}};
      end else if (dv_z_ff[F]) begin
         t_in = '0;
      end else begin
         t_in = {1'b0, dv_q_ff[F]};
      end
      tg_in = 32'(t_in) << GS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_v_ff[0] <= 1'b0;
      end else if (adv) begin
         pw_v_ff[0] <= dv_v_ff[F];
      end
      if (adv) begin
         pw_e_ff[0]     <= dv_e_ff[F];
         pw_t_ff[0]     <= t_in;
         pw_span_ff[0]  <= dv_span_ff[F];
         pw_tp_ff[0][1] <= tg_in;
         pw_up_ff[0][1] <= sms_pkg::GONE - tg_in;
         for (int j = 2; j <= DM; j++) begin
            pw_tp_ff[0][j] <= '0;
            pw_up_ff[0][j] <= '0;
         end
      end
   end

   for (genvar p = 1; p <= PW; p++) begin : g_pow
      sms_pkg::guard_type tp_in [1:DM];
      sms_pkg::guard_type up_in [1:DM];
      always_comb begin
         tp_in        = pw_tp_ff[p-1];
         up_in        = pw_up_ff[p-1];
         tp_in[p+1]   = sms_pkg::gmul(pw_tp_ff[p-1][p], pw_tp_ff[p-1][1]);
         up_in[p+1]   = sms_pkg::gmul(pw_up_ff[p-1][p], pw_up_ff[p-1][1]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            pw_v_ff[p] <= 1'b0;
         end else if (adv) begin
            pw_v_ff[p] <= pw_v_ff[p-1];
         end
         if (adv) begin
            pw_e_ff[p]    <= pw_e_ff[p-1];
            pw_t_ff[p]    <= pw_t_ff[p-1];
            pw_span_ff[p] <= pw_span_ff[p-1];
            pw_tp_ff[p]   <= tp_in;
            pw_up_ff[p]   <= up_in;
         end
      end
   end

   // ---------------- Bernstein terms and derivative ----------------
   logic               bm_v_ff, bm_e_ff;
   logic [F:0]         bm_t_ff;
   logic [31:0]        bm_span_ff;
   sms_pkg::guard_type bm_ff [0:BT-1];
   sms_pkg::guard_type dm_ff;
   sms_pkg::guard_type bm_in [0:BT-1];
   sms_pkg::guard_type dm_in;

   always_comb begin
      for (int k = 0; k < BT; k++) begin
         if (k < int'(ord)) begin
            bm_in[k] = sms_pkg::gmul(pw_tp_ff[PW][4'(ord) + 4'(k) + 4'd1],
                                     pw_up_ff[PW][4'(ord) - 4'(k)]);
         end else if (k == int'(ord)) begin
            bm_in[k] = pw_tp_ff[PW][4'(ord) + 4'(k) + 4'd1];
         end else begin
            bm_in[k] = '0;
         end
      end
      dm_in = sms_pkg::gmul(pw_tp_ff[PW][4'(ord) + 4'd1], pw_up_ff[PW][4'(ord) + 4'd1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bm_v_ff <= 1'b0;
      end else if (adv) begin
         bm_v_ff <= pw_v_ff[PW];
      end
      if (adv) begin
         bm_e_ff    <= pw_e_ff[PW];
         bm_t_ff    <= pw_t_ff[PW];
         bm_span_ff <= pw_span_ff[PW];
         bm_ff      <= bm_in;
         dm_ff      <= dm_in;
      end
   end

   // ---------------- weights ----------------
   logic                    cm_v_ff, cm_e_ff;
   logic [F:0]              cm_t_ff;
   logic [31:0]             cm_span_ff;
   logic [SUM_W-1:0]        cm_ff [0:BT-1];
   logic [sms_pkg::DG_W-1:0] cd_ff;
   logic [SUM_W-1:0]        cm_in [0:BT-1];

   always_comb begin
      for (int k = 0; k < BT; k++) begin
         cm_in[k] = SUM_W'(43'(bm_ff[k]) * 43'(sms_pkg::BERN_COEF[ord][k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_v_ff <= 1'b0;
      end else if (adv) begin
         cm_v_ff <= bm_v_ff;
      end
      if (adv) begin
         cm_e_ff    <= bm_e_ff;
         cm_t_ff    <= bm_t_ff;
         cm_span_ff <= bm_span_ff;
         cm_ff      <= cm_in;
         cd_ff      <= sms_pkg::DG_W'(46'(dm_ff) * 46'(sms_pkg::DERIV_GAIN[ord]));
      end
   end

   // ---------------- partial sums ----------------
   logic                     sa_v_ff, sa_e_ff;
   logic [F:0]               sa_t_ff;
   logic [31:0]              sa_span_ff;
   logic [SUM_W-1:0]         sa_lo_ff, sa_hi_ff;
   logic [sms_pkg::DG_W-1:0] sa_dg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else if (adv) begin
         sa_v_ff <= cm_v_ff;
      end
      if (adv) begin
         sa_e_ff    <= cm_e_ff;
         sa_t_ff    <= cm_t_ff;
         sa_span_ff <= cm_span_ff;
         sa_lo_ff   <= cm_ff[0] + cm_ff[1] + cm_ff[2] + cm_ff[3];
         sa_hi_ff   <= cm_ff[4] + cm_ff[5] + cm_ff[6];
         sa_dg_ff   <= cd_ff;
      end
   end

   // ---------------- step value and slope numerator ----------------
   logic               fn_v_ff, fn_e_ff;
   logic [31:0]        fn_span_ff;
   sms_pkg::step_type  fn_step_ff, step_in;
   logic [NUM_W-1:0]   fn_num_ff, num_in;
   logic [SW-1:0]      rnd_in, stw_in;
   logic [sms_pkg::DG_W-1:0] dg_in;

   always_comb begin
      rnd_in = SW'(sa_lo_ff) + SW'(sa_hi_ff) + (SW'(1) << (GS - 1));
      if (ord == '0) begin
         stw_in = SW'(sa_t_ff);
         dg_in  = (sa_t_ff == '0 || sa_t_ff[F]) ? '0 : sms_pkg::DG_W'(sms_pkg::GONE);
      end else begin
         stw_in = rnd_in >> GS;
         dg_in  = sa_dg_ff;
      end
      step_in = (stw_in > SW'(sms_pkg::STEP_MAX)) ? sms_pkg::STEP_MAX
                                                   : stw_in[sms_pkg::STEP_W-1:0];
      num_in  = NUM_W'(dg_in) << NUM_SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_v_ff <= 1'b0;
      end else if (adv) begin
         fn_v_ff <= sa_v_ff;
      end
      if (adv) begin
         fn_e_ff    <= sa_e_ff;
         fn_span_ff <= sa_span_ff;
         fn_step_ff <= step_in;
         fn_num_ff  <= num_in;
      end
   end

   // ---------------- slope divider ----------------
   logic               qd_v_ff    [0:QS];
   logic               qd_e_ff    [0:QS];
   logic               qd_sat_ff  [0:QS];
   logic [31:0]        qd_span_ff [0:QS];
   sms_pkg::step_type  qd_step_ff [0:QS];
   logic [DEN_W-1:0]   qd_rem_ff  [0:QS];
   logic [G-1:0]       qd_low_ff  [0:QS];
   logic [QS-1:0]      qd_q_ff    [0:QS];
   logic [DEN_W-1:0]   den0_in;

   assign den0_in = DEN_W'(fn_span_ff) << DEN_SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_v_ff[0] <= 1'b0;
      end else if (adv) begin
         qd_v_ff[0] <= fn_v_ff;
      end
      if (adv) begin
         qd_e_ff[0]    <= fn_e_ff;
         qd_sat_ff[0]  <= CW'(fn_num_ff) >= (CW'(den0_in) << G);
         qd_span_ff[0] <= fn_span_ff;
         qd_step_ff[0] <= fn_step_ff;
         qd_rem_ff[0]  <= DEN_W'(fn_num_ff >> G);
         qd_low_ff[0]  <= fn_num_ff[G-1:0];
         qd_q_ff[0]    <= '0;
      end
   end

   for (genvar i = 1; i <= QS; i++) begin : g_slope
      logic [DEN_W-1:0] den;
      logic [DEN_W:0]   sh;
      logic             ge;
      always_comb begin
         den = DEN_W'(qd_span_ff[i-1]) << DEN_SH;
         sh  = {qd_rem_ff[i-1], qd_low_ff[i-1][G-1]};
         ge  = sh >= {1'b0, den};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            qd_v_ff[i] <= 1'b0;
         end else if (adv) begin
            qd_v_ff[i] <= qd_v_ff[i-1];
         end
         if (adv) begin
            qd_e_ff[i]    <= qd_e_ff[i-1];
            qd_sat_ff[i]  <= qd_sat_ff[i-1];
            qd_span_ff[i] <= qd_span_ff[i-1];
            qd_step_ff[i] <= qd_step_ff[i-1];
            qd_rem_ff[i]  <= ge ? DEN_W'(sh - {1'b0, den}) : sh[DEN_W-1:0];
            qd_low_ff[i]  <= {qd_low_ff[i-1][G-2:0], 1'b0};
            qd_q_ff[i]    <= {qd_q_ff[i-1][QS-2:0], ge};
         end
      end
   end

   // ---------------- result ----------------
   sms_pkg::slope_type slope_out;
   sms_pkg::step_type  step_out;

   always_comb begin
      if (qd_e_ff[QS]) begin
         step_out  = '0;
         slope_out = '0;
      end else begin
         step_out  = qd_step_ff[QS];
         slope_out = qd_sat_ff[QS] ? sms_pkg::SLOPE_MAX : qd_q_ff[QS];
      end
   end

   assign adv        = !qd_v_ff[QS] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = qd_v_ff[QS];
   assign rsp_tdata  = {slope_out, step_out};
   assign rsp_tuser  = qd_e_ff[QS];

   `SMS_ASSERT_NXT_NR(a_reset_empties, clock, reset, !rsp_tvalid)
   `SMS_ASSERT_IMP(a_range_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `SMS_ASSERT_IMP(a_fill_on_advance, clock, reset, $rose(rsp_tvalid), $past(req_tready))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

typedef struct packed {
   sms_pkg::step_type  step;
   sms_pkg::slope_type slope;
   logic               range_err;
} smooth_result_type;

class smooth_scoreboard;
   logic [31:0]        lo_edge;
   logic [31:0]        hi_edge;
   sms_pkg::order_type order;
   smooth_result_type  pending[$];
   int                 errors;

   function new();
      lo_edge = 32'd0;
      hi_edge = 32'd65536;
      order   = 3'd1;
      errors  = 0;
   endfunction

   function void write_reg(sms_pkg::reg_index_type idx, logic [31:0] val);
      unique case (idx)
         sms_pkg::REG_LOWER_EDGE: lo_edge = val;
         sms_pkg::REG_UPPER_EDGE: hi_edge = val;
         sms_pkg::REG_POLY_ORDER: order = val[2:0];
         default: ;
      endcase
   endfunction

   function longint unsigned round_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function void note_sample(logic [31:0] x);
      longint lo_v, hi_v, offs;
      longint unsigned span, t, tg, ug, stp, dg, c, sum, slp;
      longint unsigned tp[14];
      longint unsigned up[14];
      int n, deg;
      smooth_result_type r;
      lo_v = longint'(signed'(lo_edge));
      hi_v = longint'(signed'(hi_edge));
      if (hi_v <= lo_v) begin
         r.step = '0;
         r.slope = '0;
         r.range_err = 1'b1;
         pending = {pending, r};
         return;
      end
      span = longint'(hi_v - lo_v);
      offs = longint'(signed'(x)) - lo_v;
      if (offs <= 0)
         t = 0;
      else if (longint'(offs) >= longint'(span))
         t = 64'd1 << 16;
      else
         t = (longint'(offs) << 16) / span;
      n = (order > sms_pkg::ORDER_TOP) ? sms_pkg::MAX_ORDER : int'(order);
      tg = t << 15;
      ug = (64'd1 << 31) - tg;
      if (n == 0) begin
         stp = t;
         dg = (t == 0 || t == (64'd1 << 16)) ? 0 : (64'd1 << 31);
      end else begin
         deg = 2 * n + 1;
         tp[0] = 64'd1 << 31;
         up[0] = 64'd1 << 31;
         for (int j = 1; j <= deg; j++) begin
            tp[j] = round_mul(tp[j-1], tg);
            up[j] = round_mul(up[j-1], ug);
         end
         c = 1;
         sum = 0;
         for (int j = 0; j <= deg; j++) begin
            if (j > n)
               sum += c * round_mul(tp[j], up[deg-j]);
            c = c * longint'(deg - j) / longint'(j + 1);
         end
         stp = (sum + (64'd1 << 14)) >> 15;
         case (n)
            1: c = 6;
            2: c = 30;
            3: c = 140;
            4: c = 630;
            5: c = 2772;
            default: c = 12012;
         endcase
         dg = c * round_mul(tp[n+1], up[n+1]);
      end
      slp = (dg << 1) / span;
      if (slp > 64'h7FFF_FFFF)
         slp = 64'h7FFF_FFFF;
      if (stp > 64'h1FFFF)
         stp = 64'h1FFFF;
      r.step = stp[16:0];
      r.slope = slp[30:0];
      r.range_err = 1'b0;
      pending = {pending, r};
   endfunction

   function void check_result(logic [47:0] data, logic user);
      smooth_result_type e;
      if (pending.size() == 0) begin
         $error("unexpected result transaction: data %h user %b", data, user);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (data[16:0] !== e.step) begin
         $error("step_value: expected %0d, actual %0d", e.step, data[16:0]);
         errors++;
      end
      if (data[47:17] !== e.slope) begin
         $error("slope: expected %0d, actual %0d", e.slope, data[47:17]);
         errors++;
      end
      if (user !== e.range_err) begin
         $error("range_error: expected %0d, actual %0d", e.range_err, user);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam sms_pkg::reg_index_type REG_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [47:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   sms_pkg::reg_index_type csr_index = sms_pkg::REG_LOWER_EDGE;
   logic [31:0]            csr_wdata = '0;

   smooth_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;

   smoothstep_with_slope uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int hold_left;
      int seen;
      hold_left = 0;
      seen = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen) begin
            seen = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_sample(logic [31:0] x);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = x;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(x);
   endtask

   task automatic write_csr(sms_pkg::reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      longint lo_v, hi_v, span, v;
      longint unsigned r;
      int sel;
      lo_v = longint'(signed'(sb.lo_edge));
      hi_v = longint'(signed'(sb.hi_edge));
      span = hi_v - lo_v;
      sel = $urandom_range(99);
      r = {$urandom, $urandom};
      if (span <= 0 || sel < 25)
         return $urandom;
      if (sel < 40)
         v = ($urandom_range(1) ? lo_v : hi_v) + longint'($urandom_range(6)) - 3;
      else
         v = lo_v - span / 8 + longint'(r % longint'(span + span / 4 + 1));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   initial begin
      logic [31:0] directed[$];
      logic [31:0] ph_lo[12];
      logic [31:0] ph_hi[12];
      logic [2:0]  ph_ord[12];
      directed = '{32'h0, 32'h10000, 32'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h1,
                   32'hFFFF, 32'hFFFFFFFF, 32'h4000, 32'hC000, 32'h5555_5555,
                   32'hAAAA_AAAA};
      ph_lo = '{32'd0, 32'd0, -32'sd262144, 32'h80000000, 32'd100, 32'd1000, 32'd5,
                -32'sd300000, 32'd0, 32'h80000000, 32'd1234, -32'sd700};
      ph_hi = '{32'd65536, 32'd65536, 32'd262144, 32'h7FFFFFFF, 32'd101, 32'd1000,
                -32'sd5, 32'd70000, 32'h7FFFFFFF, 32'h80100000, 32'd197842, 32'd300};
      ph_ord = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd6, 3'd7, 3'd6, 3'd0, 3'd1, 3'd3};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_sample(directed[i]);
      drain();

      for (int p = 0; p < 12; p++) begin
         write_csr(sms_pkg::REG_LOWER_EDGE, ph_lo[p]);
         write_csr(sms_pkg::REG_UPPER_EDGE, ph_hi[p]);
         write_csr(sms_pkg::REG_POLY_ORDER, {29'd0, ph_ord[p]});
         if (p == 4)
            write_csr(REG_SPARE, $urandom);
         case (p % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 65; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 65; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         if (p == 8) begin
            idle_pct = 0;
            stall_pct = 0;
            hold_requests++;
         end
         if (p < 2)
            foreach (directed[i])
               send_sample(directed[i]);
         for (int k = 0; k < 110; k++)
            send_sample(pick_sample());
         drain();
      end

      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

@@ smoothstep_with_slope.f @@
+incdir+src
src/sms_pkg.sv
src/smoothstep_with_slope.sv
tb/tb_top.sv
